FILE: design/gha_pkg.sv
`timescale 1ns / 1ps

package gha_pkg;

   // Port widths
   localparam int ACTION_W   = 3;
   localparam int INDEX_W    = 10;
   localparam int GEN_W      = 32;
   localparam int LOC_PORT_W = 16;
   localparam int COUNT_W    = 11;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_SLOTS       = 1024;
   localparam int DEF_LOC_FIELD_WIDTH = 16;

   localparam logic [COUNT_W-1:0] CAP_RESET   = 11'd1024;
   localparam logic [GEN_W-1:0]   FIRST_GEN   = 32'd1;
   localparam logic [GEN_W-1:0]   INVALID_GEN = 32'd0;

   // Entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [ACTION_W-1:0] {
      OP_CREATE  = 3'd0,
      OP_DESTROY = 3'd1,
      OP_LOOKUP  = 3'd2,
      OP_SETLOC  = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_NONE    = 3'd7
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   handle_ok;   // index in range and generation not invalid
      logic [INDEX_W-1:0]     index;
      logic [GEN_W-1:0]       generation;
      logic [LOC_PORT_W-1:0]  archetype;
      logic [LOC_PORT_W-1:0]  chunk;
      logic [LOC_PORT_W-1:0]  row;
   } item_type;

endpackage

FILE: design/generational_handle_allocator_unit.sv
`timescale 1ns / 1ps

// Generational handle allocator: hands out slot indices tagged with a generation,
// reuses freed slots last-in first-out, and rejects stale handles on destroy,
// lookup and set-location. Commands enter through a two-entry queue and are
// carried out one at a time by the execution unit: a slot table read, then
// update and write-back; a create that reuses a freed slot first reads the
// free stack, since the stack must be read before the slot's generation.
// A finished result waits in an output register while the next command runs.
// Write capacity only while the unit is idle; it is clipped to MAX_SLOTS.
// Slot tables need no clearing pass: liveness and generation are qualified by
// the never-used counter and a high-water mark, so the unit is ready right
// after reset and a clear-all completes like any other command.
module generational_handle_allocator_unit #(
   parameter int MAX_SLOTS       = gha_pkg::DEF_MAX_SLOTS,
   parameter int LOC_FIELD_WIDTH = gha_pkg::DEF_LOC_FIELD_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gha_pkg::ACTION_W-1:0]     req_action,
   input  logic [gha_pkg::INDEX_W-1:0]      req_handle_index,
   input  logic [gha_pkg::GEN_W-1:0]        req_handle_generation,
   input  logic [gha_pkg::LOC_PORT_W-1:0]   req_new_archetype,
   input  logic [gha_pkg::LOC_PORT_W-1:0]   req_new_chunk,
   input  logic [gha_pkg::LOC_PORT_W-1:0]   req_new_row,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [gha_pkg::INDEX_W-1:0]      rsp_out_index,
   output logic [gha_pkg::GEN_W-1:0]        rsp_out_generation,
   output logic [gha_pkg::LOC_PORT_W-1:0]   rsp_out_archetype,
   output logic [gha_pkg::LOC_PORT_W-1:0]   rsp_out_chunk,
   output logic [gha_pkg::LOC_PORT_W-1:0]   rsp_out_row,
   output logic [gha_pkg::COUNT_W-1:0]      rsp_live_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gha_pkg::COUNT_W-1:0]      csr_capacity
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > gha_pkg::COUNT_W) ? CNT_W : gha_pkg::COUNT_W;

   logic [gha_pkg::COUNT_W-1:0] capacity_ff;
   logic [CNT_W-1:0]            eff_cap;
   gha_pkg::item_type           front_item, q_head;
   logic                        q_push, q_full, q_empty, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= gha_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity;
      end
   end

   assign eff_cap = (CMP_W'(capacity_ff) > CMP_W'(MAX_SLOTS)) ?
                    CNT_W'(MAX_SLOTS) : CNT_W'(capacity_ff);

   assign req_stall = q_full;
   assign q_push    = req_valid && !req_stall;

   gha_front #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_front (
      .eff_cap               (eff_cap),
      .req_action            (req_action),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .req_new_archetype     (req_new_archetype),
      .req_new_chunk         (req_new_chunk),
      .req_new_row           (req_new_row),
      .item                  (front_item)
   );

   gha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   gha_back #(
      .MAX_SLOTS       (MAX_SLOTS),
      .LOC_FIELD_WIDTH (LOC_FIELD_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .eff_cap            (eff_cap),
      .q_empty            (q_empty),
      .head               (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_generation (rsp_out_generation),
      .rsp_out_archetype  (rsp_out_archetype),
      .rsp_out_chunk      (rsp_out_chunk),
      .rsp_out_row        (rsp_out_row),
      .rsp_live_count     (rsp_live_count)
   );

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (q_empty && !rsp_valid))
      else $error("queue or result register not cleared by reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("execution unit popped an empty queue");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |->
         (rsp_out_generation == gha_pkg::INVALID_GEN && rsp_out_archetype == '0 &&
          rsp_out_chunk == '0 && rsp_out_row == '0))
      else $error("failed operation reports a generation or location");

endmodule

FILE: design/gha_front.sv
`timescale 1ns / 1ps

module gha_front #(
   parameter int MAX_SLOTS = gha_pkg::DEF_MAX_SLOTS
) (
   input  logic [$clog2(MAX_SLOTS+1)-1:0]   eff_cap,
   input  logic [gha_pkg::ACTION_W-1:0]     req_action,
   input  logic [gha_pkg::INDEX_W-1:0]      req_handle_index,
   input  logic [gha_pkg::GEN_W-1:0]        req_handle_generation,
   input  logic [gha_pkg::LOC_PORT_W-1:0]   req_new_archetype,
   input  logic [gha_pkg::LOC_PORT_W-1:0]   req_new_chunk,
   input  logic [gha_pkg::LOC_PORT_W-1:0]   req_new_row,
   output gha_pkg::item_type                item
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > gha_pkg::INDEX_W) ? CNT_W : gha_pkg::INDEX_W;

   gha_pkg::op_type op;
   logic            in_range;

   always_comb begin
      case (req_action)
         gha_pkg::OP_CREATE:  op = gha_pkg::OP_CREATE;
         gha_pkg::OP_DESTROY: op = gha_pkg::OP_DESTROY;
         gha_pkg::OP_LOOKUP:  op = gha_pkg::OP_LOOKUP;
         gha_pkg::OP_SETLOC:  op = gha_pkg::OP_SETLOC;
         gha_pkg::OP_CLEAR:   op = gha_pkg::OP_CLEAR;
         default:             op = gha_pkg::OP_NONE;
      endcase
   end

   assign in_range = CMP_W'(req_handle_index) < CMP_W'(eff_cap);

   always_comb begin
      item            = '0;
      item.op         = op;
      item.handle_ok  = in_range && (req_handle_generation != gha_pkg::INVALID_GEN);
      item.index      = req_handle_index;
      item.generation = req_handle_generation;
      item.archetype  = req_new_archetype;
      item.chunk      = req_new_chunk;
      item.row        = req_new_row;
   end

endmodule

FILE: design/gha_queue.sv
`timescale 1ns / 1ps

module gha_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gha_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output gha_pkg::item_type head
);

   localparam int QD   = gha_pkg::QUEUE_DEPTH;
   localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int QC_W = $clog2(QD + 1);

   gha_pkg::item_type entry_ff [QD];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QC_W'(QD));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QD - 1)) ? '0 : wr_ptr_ff + QP_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QD - 1)) ? '0 : rd_ptr_ff + QP_W'(1);
      end
      count_in = count_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/gha_back.sv
`timescale 1ns / 1ps

module gha_back #(
   parameter int MAX_SLOTS       = gha_pkg::DEF_MAX_SLOTS,
   parameter int LOC_FIELD_WIDTH = gha_pkg::DEF_LOC_FIELD_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]   eff_cap,
   input  logic                             q_empty,
   input  gha_pkg::item_type                head,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [gha_pkg::INDEX_W-1:0]      rsp_out_index,
   output logic [gha_pkg::GEN_W-1:0]        rsp_out_generation,
   output logic [gha_pkg::LOC_PORT_W-1:0]   rsp_out_archetype,
   output logic [gha_pkg::LOC_PORT_W-1:0]   rsp_out_chunk,
   output logic [gha_pkg::LOC_PORT_W-1:0]   rsp_out_row,
   output logic [gha_pkg::COUNT_W-1:0]      rsp_live_count
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int LOC_W  = LOC_FIELD_WIDTH;
   localparam int LW3    = 3 * LOC_W;
   localparam int IDX_W  = gha_pkg::INDEX_W;
   localparam int GEN_W  = gha_pkg::GEN_W;
   localparam int LPW    = gha_pkg::LOC_PORT_W;
   localparam int CW     = gha_pkg::COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SLOT = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   // Slot tables and free stack
   logic [GEN_W-1:0]  gen_mem   [MAX_SLOTS];
   logic              alive_mem [MAX_SLOTS];
   logic [LW3-1:0]    loc_mem   [MAX_SLOTS];
   logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];

   state_type         state_ff, state_in;
   gha_pkg::item_type cur_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] stack_rd_ff;
   logic [GEN_W-1:0]  gen_rd_ff;
   logic              alive_rd_ff;
   logic [LW3-1:0]    loc_rd_ff;

   // free stack depth, never-used counter, live total, and the high-water mark of
   // slots ever handed out since reset (slots above it still hold the first generation)
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]  next_ff, next_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [GEN_W-1:0]  rsp_gen_ff;
   logic [LW3-1:0]    rsp_loc_ff;
   logic [CW-1:0]     rsp_live_ff;

   logic              out_free, fire, rd_en, stack_rd_en;
   logic [SLOT_W-1:0] head_slot, rd_addr;
   logic [CNT_W-1:0]  depth_m1, slot_wide;
   logic [GEN_W-1:0]  gen_eff, gen_next;
   logic              alive_eff, handle_live, from_stack, from_fresh;

   logic              ok_c;
   logic [IDX_W-1:0]  oidx_c;
   logic [GEN_W-1:0]  ogen_c;
   logic [LW3-1:0]    oloc_c;
   logic              gen_we, alive_we, alive_wdata, loc_we, stack_we;
   logic [GEN_W-1:0]  gen_wdata;
   logic [LW3-1:0]    loc_wdata;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_EXEC) && out_free;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign head_slot = SLOT_W'(head.index);
   assign depth_m1  = depth_ff - CNT_W'(1);

   always_comb begin
      if (state_ff == ST_SLOT) begin
         rd_addr = stack_rd_ff;
      end else if (head.op == gha_pkg::OP_CREATE) begin
         rd_addr = next_ff[SLOT_W-1:0];
      end else begin
         rd_addr = head_slot;
      end
   end

   assign rd_en       = q_pop || (state_ff == ST_SLOT);
   assign stack_rd_en = q_pop && (head.op == gha_pkg::OP_CREATE) && (depth_ff != '0);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               slot_in  = rd_addr;
               state_in = stack_rd_en ? ST_SLOT : ST_EXEC;
            end
         end
         ST_SLOT: begin
            slot_in  = stack_rd_ff;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Classify the slot that was read
   assign slot_wide   = CNT_W'(slot_ff);
   assign gen_eff     = (slot_wide < hw_ff) ? gen_rd_ff : gha_pkg::FIRST_GEN;
   assign alive_eff   = alive_rd_ff && (slot_wide < next_ff);
   assign handle_live = cur_ff.handle_ok && alive_eff && (gen_eff == cur_ff.generation);
   assign from_stack  = (depth_ff != '0);
   assign from_fresh  = !from_stack && (next_ff < eff_cap);
   assign gen_next    = (gen_eff + GEN_W'(1) == gha_pkg::INVALID_GEN) ?
                        gha_pkg::FIRST_GEN : gen_eff + GEN_W'(1);

   always_comb begin
      ok_c        = 1'b0;
      oidx_c      = cur_ff.index;
      ogen_c      = gha_pkg::INVALID_GEN;
      oloc_c      = '0;
      depth_in    = depth_ff;
      next_in     = next_ff;
      live_in     = live_ff;
      hw_in       = hw_ff;
      gen_we      = 1'b0;
      gen_wdata   = gen_next;
      alive_we    = 1'b0;
      alive_wdata = 1'b0;
      loc_we      = 1'b0;
      loc_wdata   = '0;
      stack_we    = 1'b0;
      case (cur_ff.op)
         gha_pkg::OP_CREATE: begin
            if (from_stack || from_fresh) begin
               ok_c        = 1'b1;
               oidx_c      = IDX_W'(slot_ff);
               ogen_c      = gen_eff;
               alive_we    = 1'b1;
               alive_wdata = 1'b1;
               loc_we      = 1'b1;
               live_in     = live_ff + CNT_W'(1);
               if (from_stack) begin
                  depth_in = depth_m1;
               end else begin
                  next_in = next_ff + CNT_W'(1);
                  // first use of this slot since reset: seed its generation
                  if (next_ff == hw_ff) begin
                     gen_we    = 1'b1;
                     gen_wdata = gha_pkg::FIRST_GEN;
                     hw_in     = hw_ff + CNT_W'(1);
                  end
               end
            end else begin
               oidx_c = '0;
            end
         end
         gha_pkg::OP_DESTROY: begin
            if (handle_live) begin
               ok_c     = 1'b1;
               alive_we = 1'b1;
               gen_we   = 1'b1;
               if (depth_ff < eff_cap) begin
                  stack_we = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
               if (live_ff != '0) begin
                  live_in = live_ff - CNT_W'(1);
               end
            end
         end
         gha_pkg::OP_LOOKUP: begin
            if (handle_live) begin
               ok_c   = 1'b1;
               oloc_c = loc_rd_ff;
            end
         end
         gha_pkg::OP_SETLOC: begin
            if (handle_live) begin
               ok_c      = 1'b1;
               loc_we    = 1'b1;
               loc_wdata = {LOC_W'(cur_ff.archetype), LOC_W'(cur_ff.chunk),
                            LOC_W'(cur_ff.row)};
            end
         end
         gha_pkg::OP_CLEAR: begin
            // alive flags fall away with the never-used counter
            ok_c     = 1'b1;
            depth_in = '0;
            next_in  = '0;
            live_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         next_ff      <= '0;
         live_ff      <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            depth_ff <= depth_in;
            next_ff  <= next_in;
            live_ff  <= live_in;
            hw_ff    <= hw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (q_pop) begin
         cur_ff <= head;
      end
      if (fire) begin
         rsp_ok_ff    <= ok_c;
         rsp_index_ff <= oidx_c;
         rsp_gen_ff   <= ogen_c;
         rsp_loc_ff   <= oloc_c;
         rsp_live_ff  <= CW'(live_in);
      end
   end

   always_ff @(posedge clock) begin
      if (fire && gen_we) begin
         gen_mem[slot_ff] <= gen_wdata;
      end
      if (rd_en) begin
         gen_rd_ff <= gen_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fire && alive_we) begin
         alive_mem[slot_ff] <= alive_wdata;
      end
      if (rd_en) begin
         alive_rd_ff <= alive_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fire && loc_we) begin
         loc_mem[slot_ff] <= loc_wdata;
      end
      if (rd_en) begin
         loc_rd_ff <= loc_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fire && stack_we) begin
         stack_mem[depth_ff[SLOT_W-1:0]] <= slot_ff;
      end
      if (stack_rd_en) begin
         stack_rd_ff <= stack_mem[depth_m1[SLOT_W-1:0]];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_out_index      = rsp_index_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_out_archetype  = LPW'(rsp_loc_ff[LW3-1 -: LOC_W]);
   assign rsp_out_chunk      = LPW'(rsp_loc_ff[2*LOC_W-1 -: LOC_W]);
   assign rsp_out_row        = LPW'(rsp_loc_ff[LOC_W-1:0]);
   assign rsp_live_count     = rsp_live_ff;

endmodule
